>>> src/sync_word_frame_deframer_defines.svh
// Assertion macros for the sync word frame deframer.
`ifndef SYNC_WORD_FRAME_DEFRAMER_DEFINES_SVH
`define SYNC_WORD_FRAME_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWFD_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWFD_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/swfd_pkg.sv
// Shared types and constants of the sync word frame deframer.
package swfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned LIMIT_W  = 13;
    localparam int unsigned SKIP_W   = 12;
    localparam int unsigned RATE_W   = 3;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0]  SYNC_RESET  = 16'd33279;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd512;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 13'd12;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 13'd4096;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 11'd2047;
    localparam logic [LIMIT_W-1:0] HEADER_BYTES = 13'd10;
    localparam logic [LIMIT_W-1:0] CHECK_BYTES  = 13'd2;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 3'd2;
    localparam logic [RATE_W-1:0]  RATE_LAST   = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_WORD = 2'd0,
        CFG_MAX_BYTES = 2'd1
    } cfg_index_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA       = 3'd0,
        KIND_FRAME_OK   = 3'd1,
        KIND_HEADER_ERR = 3'd2,
        KIND_DATA_ERR   = 3'd3,
        KIND_RESPONSE   = 3'd4,
        KIND_BAUD_STEP  = 3'd5,
        KIND_LENGTH_ERR = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'b001,
        PH_HEADER = 3'b010,
        PH_DATA   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [WORD_W-1:0]  sync_word;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [WORD_W-1:0]  word_value;
        logic [WORD_W-1:0]  message_id;
        logic [COUNT_W-1:0] data_word_count;
        logic [RATE_W-1:0]  baud_code;
    } result_t;

endpackage

>>> src/swfd_cfg.sv
// Configuration registers with the frame length limit clamped on write.
module swfd_cfg
    import swfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    logic [WORD_W-1:0]  sync_reg;
    logic [WORD_W-1:0]  sync_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;
    logic [LIMIT_W-1:0] limit_clamped;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        limit_clamped = cfg_data[LIMIT_W-1:0];
        if (limit_clamped < LIMIT_MIN)
        begin
            limit_clamped = LIMIT_MIN;
        end
        else if (limit_clamped > LIMIT_MAX)
        begin
            limit_clamped = LIMIT_MAX;
        end
    end

    always_comb
    begin
        sync_next  = sync_reg;
        limit_next = limit_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SYNC_WORD: sync_next  = cfg_data;
                CFG_MAX_BYTES: limit_next = limit_clamped;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg  <= SYNC_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            sync_reg  <= sync_next;
            limit_reg <= limit_next;
        end
    end

    assign cfg.sync_word = sync_reg;
    assign cfg.limit     = limit_reg;

endmodule

>>> src/swfd_core.sv
// Framing state and the per-byte next-state and result logic.
module swfd_core
    import swfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  cfg_t              cfg,
    output logic              res_valid,
    output result_t           res
);

    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  prev_reg, prev_next;
    logic               have_prev_reg, have_prev_next;
    logic               low_pend_reg, low_pend_next;
    logic [COUNT_W-1:0] pos_reg, pos_next;
    logic [WORD_W-1:0]  sum_reg, sum_next;
    logic [WORD_W-1:0]  id_reg, id_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0]  flags_reg, flags_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;

    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  sum_add;
    logic [LIMIT_W-1:0] skip_inc;
    logic [LIMIT_W-1:0] total;

    assign word     = {rx_byte, prev_reg};
    assign sum_add  = sum_reg + word;
    assign skip_inc = {1'b0, skip_reg} + 13'd1;
    assign total    = HEADER_BYTES + {1'b0, count_reg, 1'b0}
                      + ((count_reg != '0) ? CHECK_BYTES : '0);

    always_comb
    begin
        phase_next     = phase_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        low_pend_next  = low_pend_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        id_next        = id_reg;
        count_next     = count_reg;
        flags_next     = flags_reg;
        skip_next      = skip_reg;
        rate_next      = rate_reg;
        res_valid      = 1'b0;
        res            = '0;

        unique case (phase_reg)
            PH_HEADER, PH_DATA:
            begin
                if (!low_pend_reg)
                begin
                    prev_next     = rx_byte;
                    low_pend_next = 1'b1;
                end
                else
                begin
                    low_pend_next = 1'b0;
                    sum_next      = sum_add;
                    if (phase_reg == PH_HEADER)
                    begin
                        pos_next = pos_reg + 11'd1;
                        priority if (pos_reg == 11'd1)
                        begin
                            id_next = word;
                        end
                        else if (pos_reg == 11'd2)
                        begin
                            count_next = (word > {5'd0, COUNT_MAX}) ? COUNT_MAX
                                                                    : word[COUNT_W-1:0];
                        end
                        else if (pos_reg == 11'd3)
                        begin
                            flags_next = word;
                        end
                        else
                        begin
                            res.message_id      = id_reg;
                            res.data_word_count = count_reg;
                            phase_next          = PH_HUNT;
                            have_prev_next      = 1'b0;
                            pos_next            = '0;
                            sum_next            = '0;
                            priority if (sum_add != '0)
                            begin
                                res_valid = 1'b1;
                                res.kind  = KIND_HEADER_ERR;
                            end
                            else if (total > cfg.limit)
                            begin
                                res_valid = 1'b1;
                                res.kind  = KIND_LENGTH_ERR;
                            end
                            else if (count_reg == '0)
                            begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_RESPONSE;
                                res.word_value = flags_reg;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                    end
                    else
                    begin
                        res_valid           = 1'b1;
                        res.message_id      = id_reg;
                        res.data_word_count = count_reg;
                        if (pos_reg < count_reg)
                        begin
                            pos_next       = pos_reg + 11'd1;
                            res.kind       = KIND_DATA;
                            res.word_value = word;
                        end
                        else
                        begin
                            res.kind       = (sum_add == '0) ? KIND_FRAME_OK : KIND_DATA_ERR;
                            phase_next     = PH_HUNT;
                            have_prev_next = 1'b0;
                            pos_next       = '0;
                            sum_next       = '0;
                        end
                    end
                end
            end
            default:
            begin
                prev_next = rx_byte;
                if (!have_prev_reg)
                begin
                    have_prev_next = 1'b1;
                end
                else if (word == cfg.sync_word)
                begin
                    prev_next      = prev_reg;
                    phase_next     = PH_HEADER;
                    have_prev_next = 1'b0;
                    low_pend_next  = 1'b0;
                    pos_next       = 11'd1;
                    sum_next       = word;
                    skip_next      = '0;
                end
                else if (skip_inc >= cfg.limit)
                begin
                    skip_next = '0;
                    rate_next = (rate_reg < RATE_LAST) ? rate_reg + 3'd1 : '0;
                    res_valid = 1'b1;
                    res.kind  = KIND_BAUD_STEP;
                end
                else
                begin
                    skip_next = skip_inc[SKIP_W-1:0];
                end
            end
        endcase

        res.baud_code = rate_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            low_pend_reg  <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            id_reg        <= '0;
            count_reg     <= '0;
            flags_reg     <= '0;
            skip_reg      <= '0;
            rate_reg      <= RATE_RESET;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            low_pend_reg  <= low_pend_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            id_reg        <= id_next;
            count_reg     <= count_next;
            flags_reg     <= flags_next;
            skip_reg      <= skip_next;
            rate_reg      <= rate_next;
        end
    end

endmodule

>>> src/sync_word_frame_deframer.sv
// Top level of the sync word frame deframer: input register, core and result register.
//
//   Channel  Signals                                    Direction
//   in       in_valid, in_ready, rx_byte                into the block
//   out      out_valid, out_ready, kind, word_value,    out of the block
//            message_id, data_word_count, baud_code
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  into the block
//
// One byte beat is accepted every cycle while results are taken.
// A byte passes the input register and the framing logic into the result register.
// Reset is asynchronous and needs no clearing pass; configuration is always ready.
// A stalled result holds one byte in the input register and then drops in_ready.
module sync_word_frame_deframer
    import swfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    kind,
    output logic [WORD_W-1:0]    word_value,
    output logic [WORD_W-1:0]    message_id,
    output logic [COUNT_W-1:0]   data_word_count,
    output logic [RATE_W-1:0]    baud_code
);

`include "sync_word_frame_deframer_defines.svh"

    cfg_t              cfg;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    logic              step;
    logic              res_valid;
    result_t           res;

    swfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swfd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = res_valid;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign word_value      = out_reg.word_value;
    assign message_id      = out_reg.message_id;
    assign data_word_count = out_reg.data_word_count;
    assign baud_code       = out_reg.baud_code;

    `SWFD_CHECK_NOW(a_stall_cause, !in_ready, in_valid_reg && out_valid_reg && !out_ready, "in_ready low without a stalled result")
    `SWFD_CHECK_NEXT(a_result_shown, step && res_valid, out_valid, "computed result not presented")
    `SWFD_CHECK_NOW(a_data_count, out_valid && (kind == KIND_DATA), data_word_count != '0, "data word with zero declared count")
    `SWFD_CHECK_NOW(a_baud_fields, out_valid && (kind == KIND_BAUD_STEP), (word_value == '0) && (message_id == '0) && (data_word_count == '0), "baud step carries frame fields")

endmodule

>>> sim/sync_word_frame_deframer_tb.sv
// Self-checking testbench for the sync word frame deframer, with a byte-level frame predictor.
`timescale 1ns / 1ps

module sync_word_frame_deframer_tb;
    import swfd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 clk;
    logic                 rst_n           = 1'b0;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [WORD_W-1:0]    cfg_data        = '0;
    logic                 in_valid        = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte         = '0;
    logic                 out_valid;
    logic                 out_ready       = 1'b0;
    logic [KIND_W-1:0]    kind;
    logic [WORD_W-1:0]    word_value;
    logic [WORD_W-1:0]    message_id;
    logic [COUNT_W-1:0]   data_word_count;
    logic [RATE_W-1:0]    baud_code;

    logic [BYTE_W-1:0] rx_pending[$];
    result_t           pending_reports[$];
    int                bad_reports     = 0;
    int                cycle_count     = 0;
    bit                in_taken        = 1'b0;
    bit                idle_on         = 1'b1;
    int                send_gap        = 0;
    int                hold_left       = 0;
    int                long_hold_asks  = 0;
    int                long_hold_seen  = 0;

    logic [WORD_W-1:0] sync_now  = SYNC_RESET;
    int                limit_now = LIMIT_RESET;

    phase_t             trk_phase   = PH_HUNT;
    logic [BYTE_W-1:0]  held_byte   = '0;
    bit                 held_valid  = 1'b0;
    bit                 low_waiting = 1'b0;
    logic [COUNT_W-1:0] word_index  = '0;
    logic [WORD_W-1:0]  word_sum    = '0;
    logic [WORD_W-1:0]  hdr_id      = '0;
    logic [COUNT_W-1:0] hdr_count   = '0;
    logic [WORD_W-1:0]  hdr_flags   = '0;
    int                 skip_run    = 0;
    logic [RATE_W-1:0]  rate_now    = RATE_RESET;
    logic [WORD_W-1:0]  sync_cfg    = SYNC_RESET;
    logic [LIMIT_W-1:0] limit_cfg   = LIMIT_RESET;

    sync_word_frame_deframer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .word_value      (word_value),
        .message_id      (message_id),
        .data_word_count (data_word_count),
        .baud_code       (baud_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int clamp_limit(input logic [LIMIT_W-1:0] raw);
        if (raw < LIMIT_MIN)
        begin
            return LIMIT_MIN;
        end
        if (raw > LIMIT_MAX)
        begin
            return LIMIT_MAX;
        end
        return raw;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [WORD_W-1:0] value);
        case (idx)
            CFG_SYNC_WORD: sync_cfg = value;
            CFG_MAX_BYTES: limit_cfg = value[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void restart_hunt();
        trk_phase   = PH_HUNT;
        held_valid  = 1'b0;
        low_waiting = 1'b0;
        word_index  = '0;
        word_sum    = '0;
    endfunction

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t rep);
        logic [WORD_W-1:0] w;
        int                n;
        rep = '0;
        rep.baud_code = rate_now;
        w = {b, held_byte};
        if (trk_phase != PH_HEADER && trk_phase != PH_DATA)
        begin
            if (!held_valid)
            begin
                held_byte  = b;
                held_valid = 1'b1;
                return 1'b0;
            end
            if (w == sync_cfg)
            begin
                trk_phase   = PH_HEADER;
                held_valid  = 1'b0;
                low_waiting = 1'b0;
                word_index  = 11'd1;
                word_sum    = w;
                skip_run    = 0;
                return 1'b0;
            end
            held_byte = b;
            skip_run++;
            if (skip_run < clamp_limit(limit_cfg))
            begin
                return 1'b0;
            end
            skip_run = 0;
            rate_now = (rate_now < RATE_LAST) ? rate_now + 3'd1 : 3'd0;
            rep.kind      = KIND_BAUD_STEP;
            rep.baud_code = rate_now;
            return 1'b1;
        end
        if (!low_waiting)
        begin
            held_byte   = b;
            low_waiting = 1'b1;
            return 1'b0;
        end
        low_waiting = 1'b0;
        word_sum = word_sum + w;
        if (trk_phase == PH_HEADER)
        begin
            if (word_index < 11'd4)
            begin
                case (word_index)
                    11'd1: hdr_id = w;
                    11'd2: hdr_count = (w > COUNT_MAX) ? COUNT_MAX : w[COUNT_W-1:0];
                    default: hdr_flags = w;
                endcase
                word_index++;
                return 1'b0;
            end
            n = hdr_count;
            rep.message_id      = hdr_id;
            rep.data_word_count = hdr_count;
            if (word_sum != '0)
            begin
                rep.kind = KIND_HEADER_ERR;
            end
            else if (int'(HEADER_BYTES) + 2 * n + ((n != 0) ? int'(CHECK_BYTES) : 0)
                     > clamp_limit(limit_cfg))
            begin
                rep.kind = KIND_LENGTH_ERR;
            end
            else if (n == 0)
            begin
                rep.kind       = KIND_RESPONSE;
                rep.word_value = hdr_flags;
            end
            else
            begin
                trk_phase  = PH_DATA;
                word_index = '0;
                word_sum   = '0;
                return 1'b0;
            end
            restart_hunt();
            return 1'b1;
        end
        rep.message_id      = hdr_id;
        rep.data_word_count = hdr_count;
        if (word_index < hdr_count)
        begin
            word_index++;
            rep.kind       = KIND_DATA;
            rep.word_value = w;
            return 1'b1;
        end
        if (word_sum == '0)
        begin
            rep.kind = KIND_FRAME_OK;
        end
        else
        begin
            rep.kind = KIND_DATA_ERR;
        end
        restart_hunt();
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        result_t fresh;
        result_t head;
        cycle_count <= cycle_count + 1;
        in_taken    <= in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                if (deframe_byte(rx_byte, fresh))
                begin
                    pending_reports.push_back(fresh);
                end
            end
            if (out_valid === 1'b1 && out_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result beat with nothing expected: kind %0d word %h", kind, word_value);
                    bad_reports++;
                end
                else
                begin
                    head = pending_reports.pop_front();
                    if (kind !== head.kind)
                    begin
                        $error("kind: expected %0d, got %0d", head.kind, kind);
                        bad_reports++;
                    end
                    if (word_value !== head.word_value)
                    begin
                        $error("word_value: expected %h, got %h", head.word_value, word_value);
                        bad_reports++;
                    end
                    if (message_id !== head.message_id)
                    begin
                        $error("message_id: expected %h, got %h", head.message_id, message_id);
                        bad_reports++;
                    end
                    if (data_word_count !== head.data_word_count)
                    begin
                        $error("data_word_count: expected %0d, got %0d",
                               head.data_word_count, data_word_count);
                        bad_reports++;
                    end
                    if (baud_code !== head.baud_code)
                    begin
                        $error("baud_code: expected %0d, got %0d", head.baud_code, baud_code);
                        bad_reports++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 15) == 0)
            begin
                send_gap <= $urandom_range(0, 16);
                in_valid <= 1'b0;
            end
            else if (rx_pending.size() > 0)
            begin
                in_valid <= 1'b1;
                rx_byte  <= rx_pending.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (long_hold_seen != long_hold_asks)
        begin
            long_hold_seen <= long_hold_asks;
            hold_left      <= LONG_HOLD;
            out_ready      <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 15) == 0)
        begin
            hold_left <= $urandom_range(0, 16);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
    endtask

    task automatic set_config(input logic [WORD_W-1:0] sync, input logic [WORD_W-1:0] limit_raw);
        write_reg(CFG_SYNC_WORD, sync);
        write_reg(CFG_MAX_BYTES, limit_raw);
        @(negedge clk);
        cfg_valid <= 1'b0;
        sync_now  = sync;
        limit_now = clamp_limit(limit_raw[LIMIT_W-1:0]);
    endtask

    task automatic wait_quiet();
        do @(posedge clk);
        while (rx_pending.size() != 0 || in_valid || pending_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void add_word(ref logic [BYTE_W-1:0] q[$], input logic [WORD_W-1:0] w);
        q.push_back(w[7:0]);
        q.push_back(w[15:8]);
    endfunction

    function automatic int queue_noise(input int count, input int lo, input int hi);
        repeat (count) rx_pending.push_back(BYTE_W'($urandom_range(lo, hi)));
        return count;
    endfunction

    // The payload only follows a header that the block will accept.
    function automatic int queue_frame(input logic [WORD_W-1:0] id,
                                       input logic [WORD_W-1:0] count_word,
                                       input logic [WORD_W-1:0] flags,
                                       input bit bad_hdr, input bit bad_data, input int cut);
        logic [BYTE_W-1:0] fb[$];
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] w;
        int                n;
        n = (count_word > COUNT_MAX) ? COUNT_MAX : count_word;
        sum = sync_now + id + count_word + flags;
        add_word(fb, sync_now);
        add_word(fb, id);
        add_word(fb, count_word);
        add_word(fb, flags);
        add_word(fb, (16'd0 - sum) + (bad_hdr ? 16'($urandom_range(1, 65535)) : 16'd0));
        if (!bad_hdr && n != 0
            && int'(HEADER_BYTES) + 2 * n + int'(CHECK_BYTES) <= limit_now)
        begin
            sum = '0;
            for (int i = 0; i < n; i++)
            begin
                w = 16'($urandom);
                sum = sum + w;
                add_word(fb, w);
            end
            add_word(fb, (16'd0 - sum) + (bad_data ? 16'($urandom_range(1, 65535)) : 16'd0));
        end
        for (int i = 0; i < fb.size() - cut; i++)
        begin
            rx_pending.push_back(fb[i]);
        end
        return fb.size() - cut;
    endfunction

    task automatic random_frames(input int budget);
        int queued;
        int nmax;
        int n;
        int pick;
        queued = 0;
        nmax = (limit_now - int'(HEADER_BYTES) - int'(CHECK_BYTES)) / 2;
        while (queued < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                queued += queue_noise($urandom_range(1, 24), 0, 255);
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    queued += queue_noise($urandom_range(1, 3), 0, 255);
                end
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    n = $urandom_range(0, (nmax < 10) ? nmax : 10);
                end
                else if (pick < 70)
                begin
                    n = (nmax <= 64) ? nmax : $urandom_range(11, 64);
                end
                else if (pick < 82)
                begin
                    n = nmax + 1;
                end
                else if (pick < 86)
                begin
                    n = $urandom_range(2048, 65535);
                end
                else
                begin
                    n = 0;
                end
                queued += queue_frame(16'($urandom), 16'(n), 16'($urandom),
                                      $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 8,
                                      ($urandom_range(0, 99) < 5) ? $urandom_range(1, 8) : 0);
            end
        end
    endtask

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("sync_word_frame_deframer: mismatch");
        $finish;
    end

    initial
    begin
        logic [WORD_W-1:0] phase_limit;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        void'(queue_frame(16'h0000, 16'd0, 16'hFFFF, 1'b0, 1'b0, 0));
        void'(queue_frame(16'hFFFF, 16'd1, 16'h0000, 1'b0, 1'b0, 0));
        void'(queue_frame(16'h1234, 16'd2, 16'h5555, 1'b0, 1'b1, 0));
        void'(queue_frame(16'hAAAA, 16'd3, 16'h0000, 1'b1, 1'b0, 0));
        void'(queue_frame(16'h0F0F, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 0));
        void'(queue_frame(16'h0007, 16'h0800, 16'h0000, 1'b0, 1'b0, 0));
        void'(queue_frame(16'h0008, 16'h07FF, 16'h0000, 1'b0, 1'b0, 0));
        wait_quiet();

        // Limit below the floor; nonzero noise cannot form the zero sync word.
        set_config(16'h0000, 16'h0000);
        void'(queue_frame(16'h0001, 16'd0, 16'h8001, 1'b0, 1'b0, 0));
        void'(queue_frame(16'h0002, 16'd1, 16'h0000, 1'b0, 1'b0, 0));
        void'(queue_noise(65, 1, 255));
        wait_quiet();

        set_config(16'hFFFF, 16'd16);
        void'(queue_frame(16'h0003, 16'd2, 16'h0000, 1'b0, 1'b0, 0));
        void'(queue_frame(16'h0004, 16'd3, 16'h0000, 1'b0, 1'b0, 0));
        void'(queue_frame(16'h0005, 16'd1, 16'h0000, 1'b0, 1'b0, 0));
        wait_quiet();

        write_reg(CFG_SPARE_A, 16'($urandom));
        write_reg(CFG_SPARE_B, 16'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: phase_limit = 16'($urandom_range(41, 300));
                1: phase_limit = 16'($urandom_range(12, 40));
                2: phase_limit = 16'(LIMIT_MAX);
                default: phase_limit = 16'($urandom_range(0, 11));
            endcase
            set_config(16'($urandom), phase_limit);
            idle_on = (p < 2);
            random_frames(80);
            if (p == 0)
            begin
                long_hold_asks++;
            end
            wait_quiet();
        end

        // Raw limit above the range acts as the largest limit.
        idle_on = 1'b0;
        set_config(16'h1234, 16'hFFFF);
        void'(queue_frame(16'h0009, 16'd2, 16'h00FF, 1'b0, 1'b0, 0));
        void'(queue_frame(16'h000A, 16'd2043, 16'h0000, 1'b0, 1'b0, 0));
        wait_quiet();

        if (bad_reports == 0 && pending_reports.size() == 0)
        begin
            $display("sync_word_frame_deframer: match");
        end
        else
        begin
            $display("sync_word_frame_deframer: mismatch");
        end
        $finish;
    end

endmodule
